>>> rtl/double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Deque assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge outside of reset.
`define DEQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("double_ended_queue: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("double_ended_queue: assertion failed");
`else
`define DEQ_ASSERT(lbl, clk, rstn, prop)
`define DEQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Command and error codes, sequencer states and the control bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_BACK   = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_READ_INDEX = 3'd4,
    CMD_WRITE_INDEX = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_OVERFLOW = 2'd2,
    ERR_RANGE    = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DATA  = 4'b0010,
    ST_FRONT = 4'b0100,
    ST_BACK  = 4'b1000
  } st_e;

  // Control from the sequencer to the result stage.
  typedef struct packed {
    logic cap_data;
    logic cap_front;
    logic cap_back;
    logic data_ok;
    logic nonempty;
    logic full;
    err_e err;
  } ctl_t;

endpackage

>>> rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// Deque RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque sequencer
// Holds head and occupancy, decodes commands and steps the RAM reads.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [2:0]                 command_i,
  input  logic [3:0]                 index_i,
  output logic                       busy_o,
  output logic                       ram_we_o,
  output logic [$clog2(DEPTH)-1:0]   ram_waddr_o,
  output logic [$clog2(DEPTH)-1:0]   ram_raddr_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output dq_pkg::ctl_t               ctl_o
);
  import dq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

  st_e              st_q, st_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] occ_q, occ_d;
  err_e             err_q, err_d;
  logic             ok_q, ok_d;
  cmd_e             cmd;
  logic             empty, full, idx_bad;
  logic [CNT_W-1:0] idx;
  logic [PTR_W-1:0] head_dec;

  // Ring slot of position pos counted from head; the sum stays below 2*DEPTH.
  function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] h,
                                            input logic [CNT_W-1:0] pos);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(pos);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  assign cmd      = cmd_e'(command_i);
  assign empty    = (occ_q == '0);
  assign full     = (occ_q == CNT_W'(DEPTH));
  assign idx_bad  = (CMP_W'(index_i) >= CMP_W'(occ_q));
  assign idx      = CNT_W'(CMP_W'(index_i));
  assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - 1'b1;

  always_comb begin
    st_d        = st_q;
    head_d      = head_q;
    occ_d       = occ_q;
    err_d       = err_q;
    ok_d        = ok_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot(head_q, idx);
    ram_raddr_o = slot(head_q, idx);
    unique case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          st_d  = ST_DATA;
          err_d = ERR_NONE;
          ok_d  = 1'b0;
          unique case (cmd)
            CMD_PUSH_BACK: begin
              if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = slot(head_q, occ_q);
                occ_d       = occ_q + 1'b1;
              end
            end
            CMD_PUSH_FRONT: begin
              if (full) begin
                err_d = ERR_OVERFLOW;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = head_dec;
                head_d      = head_dec;
                occ_d       = occ_q + 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end else begin
                ram_raddr_o = slot(head_q, occ_q - 1'b1);
                ok_d        = 1'b1;
                occ_d       = occ_q - 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end else begin
                ram_raddr_o = head_q;
                ok_d        = 1'b1;
                head_d      = slot(head_q, CNT_W'(1));
                occ_d       = occ_q - 1'b1;
              end
            end
            CMD_READ_INDEX: begin
              if (empty) begin
                err_d = ERR_EMPTY;
              end else if (idx_bad) begin
                err_d = ERR_RANGE;
              end else begin
                ok_d = 1'b1;
              end
            end
            CMD_WRITE_INDEX: begin
              if (idx_bad) begin
                err_d = ERR_RANGE;
              end else begin
                ram_we_o = 1'b1;
              end
            end
            CMD_CLEAR: begin
              occ_d  = '0;
              head_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DATA: begin
        ram_raddr_o = head_q;
        st_d        = ST_FRONT;
      end
      ST_FRONT: begin
        ram_raddr_o = empty ? '0 : slot(head_q, occ_q - 1'b1);
        st_d        = ST_BACK;
      end
      ST_BACK: begin
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      head_q <= '0;
      occ_q  <= '0;
      err_q  <= ERR_NONE;
      ok_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      head_q <= head_d;
      occ_q  <= occ_d;
      err_q  <= err_d;
      ok_q   <= ok_d;
    end
  end

  assign busy_o          = (st_q != ST_IDLE);
  assign count_o         = occ_q;
  assign ctl_o.cap_data  = (st_q == ST_DATA);
  assign ctl_o.cap_front = (st_q == ST_FRONT);
  assign ctl_o.cap_back  = (st_q == ST_BACK);
  assign ctl_o.data_ok   = ok_q;
  assign ctl_o.nonempty  = !empty;
  assign ctl_o.full      = full;
  assign ctl_o.err       = err_q;

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of words kept in a RAM ring buffer with head and occupancy.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer is taken at a rising edge where start_i is high and
// busy_o is low; command_i, value_i and index_i are sampled at that edge.
// Commands push or pop at either end, read or overwrite a word by its
// position from the front, or clear the queue.
// Every command produces exactly one result transfer: valid_o is high for
// one cycle, with the popped or read word, the count after the command,
// empty and full flags, the front and back words and an error code.
// After the transfer the sequencer walks the states ST_DATA, ST_FRONT and
// ST_BACK: the single read port of the store RAM is used once for the
// popped or read word, once for the front word and once for the back word,
// and the result is then registered. busy_o is high from a transfer until
// the result is presented; a new command may be given in that cycle.
// Reset empties the queue; the RAM contents are not cleared, since only
// stored words are ever read. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int WORD_WIDTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 command_i,
  input  logic [WORD_WIDTH-1:0]      value_i,
  input  logic [3:0]                 index_i,
  output logic                       valid_o,
  output logic [WORD_WIDTH-1:0]      data_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic                       is_empty_o,
  output logic                       is_full_o,
  output logic [WORD_WIDTH-1:0]      front_word_o,
  output logic [WORD_WIDTH-1:0]      back_word_o,
  output logic [1:0]                 error_o
);
  import dq_pkg::*;

  `include "double_ended_queue_assert.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;
  logic [CNT_W-1:0]      count;
  ctl_t                  ctl;

  // Partial result words collected while the sequencer walks the reads.
  logic [WORD_WIDTH-1:0] data_q, front_q;
  logic                  valid_q;

  // Result registers.
  logic [WORD_WIDTH-1:0] res_data_q, res_front_q, res_back_q;
  logic [CNT_W-1:0]      res_count_q;
  logic                  res_empty_q, res_full_q;
  err_e                  res_err_q;

  // Consistency of the presented result, used by the checks below.
  logic                  result_sane;

  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .command_i   (command_i),
    .index_i     (index_i),
    .busy_o      (busy_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_raddr_o (ram_raddr),
    .count_o     (count),
    .ctl_o       (ctl)
  );

  // The only write happens at the command transfer edge, so every later
  // read of the same command already sees the updated entry.
  dq_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Words are zeroed when the command had no valid read or the queue is
  // empty; the back word is zeroed as it enters the result registers.
  always_ff @(posedge clk_i) begin
    if (ctl.cap_data) begin
      data_q <= ctl.data_ok ? ram_rdata : '0;
    end
    if (ctl.cap_front) begin
      front_q <= ctl.nonempty ? ram_rdata : '0;
    end
    if (ctl.cap_back) begin
      res_data_q  <= data_q;
      res_front_q <= front_q;
      res_back_q  <= ctl.nonempty ? ram_rdata : '0;
      res_count_q <= count;
      res_empty_q <= !ctl.nonempty;
      res_full_q  <= ctl.full;
      res_err_q   <= ctl.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl.cap_back;
    end
  end

  assign valid_o      = valid_q;
  assign data_o       = res_data_q;
  assign count_o      = res_count_q;
  assign is_empty_o   = res_empty_q;
  assign is_full_o    = res_full_q;
  assign front_word_o = res_front_q;
  assign back_word_o  = res_back_q;
  assign error_o      = res_err_q;

  assign result_sane = (count_o <= CNT_W'(DEPTH)) &&
                       ((error_o == ERR_NONE) || (data_o == '0));

  // A taken command keeps the block busy in the following cycle.
  `DEQ_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // Each taken command produces its result after ST_DATA, ST_FRONT and ST_BACK.
  `DEQ_ASSERT(a_result_latency, clk_i, rst_ni, (start_i && !busy_o) |-> ##4 valid_o)
  // The result strobe never overlaps the busy window of a command.
  `DEQ_ASSERT(a_valid_not_busy, clk_i, rst_ni, valid_o |-> !busy_o)
  // Failed pops and reads return a zero word and the count stays in range.
  `DEQ_ASSERT(a_result_sane, clk_i, rst_ni, valid_o |-> result_sane)

endmodule
